FILE: rtl/core/can_id_frame_statistics_table_defines.svh
// ----------------------------------------------------------------------------
// can id statistics table assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef CAN_ID_FRAME_STATISTICS_TABLE_DEFINES_SVH
`define CAN_ID_FRAME_STATISTICS_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define CIDST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define CIDST_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CIDST_ASSERT(lbl, clk, rst_n, prop, msg)
`define CIDST_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/core/cidst_pkg.sv
// ----------------------------------------------------------------------------
// cidst_pkg
// shared types and codes of the can id statistics table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cidst_pkg;

	// result status codes
	localparam logic [2:0] STAT_NEW     = 3'd0;
	localparam logic [2:0] STAT_UPDATED = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_ENTRY   = 3'd3;
	localparam logic [2:0] STAT_END     = 3'd4;

	localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

	// one table slot as stored in the slot memory
	typedef struct packed {
		logic [28:0] id;
		logic        ext;
		logic [31:0] count;
		logic [63:0] first_time;
		logic [63:0] last_time;
		logic [3:0]  dlc;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_REC_SCAN = 6'b000010,
		ST_REC_FIN  = 6'b000100,
		ST_SNAP_RD  = 6'b001000,
		ST_SNAP_OUT = 6'b010000,
		ST_SNAP_END = 6'b100000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/cidst_ram.sv
// ----------------------------------------------------------------------------
// cidst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cidst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/can_id_frame_statistics_table.sv
// ----------------------------------------------------------------------------
// can_id_frame_statistics_table
// per-identifier statistics of received can frames, with table snapshot
// ----------------------------------------------------------------------------
// The slot table lives in one ram with a single read port, and a small
// sequencer walks it slot by slot. A record transfer scans the slots in
// order, one read per cycle, and stops at the first slot that matches;
// its result is loaded into the output register from ST_REC_FIN, and the
// next input is taken in the cycle after that. A snapshot skips unused
// slots, reads each used one and emits it, up to max_copies entries, then
// the end item. Input is taken only between commands; results wait in an
// output register while the consumer stalls. Valid marks are flip-flops
// cleared by reset, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "can_id_frame_statistics_table_defines.svh"

module can_id_frame_statistics_table #(
	parameter int TABLE_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [28:0] can_id,
	input  logic        extended_format,
	input  logic [63:0] rx_time,
	input  logic [3:0]  data_length_code,
	input  logic [6:0]  max_copies,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [28:0] entry_id,
	output logic        entry_extended,
	output logic [31:0] entry_count,
	output logic [63:0] entry_first_time,
	output logic [63:0] entry_last_time,
	output logic [3:0]  entry_dlc,
	output logic [6:0]  copied_count,
	output logic        last
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [CW-1:0] SLOT_END  = CW'(TABLE_SLOTS);
	localparam logic [IW-1:0] SLOT_LAST = IW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0] IDX_ONE   = CW'(1);

	cidst_pkg::state_t state_q, state_d;

	logic [CW-1:0]          idx_q;
	logic [IW-1:0]          idx_s1;
	logic                   chk_s1;
	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;
	logic [6:0]             n_q;
	logic [TABLE_SLOTS-1:0] valid_q;

	logic [28:0] id_q;
	logic        ext_q;
	logic [63:0] time_q;
	logic [3:0]  dlc_q;
	logic [6:0]  max_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        last_q;
	logic [6:0]  copied_q;
	cidst_pkg::entry_t out_entry_q;

	logic in_acc_c;
	logic out_free_c;
	logic hit_c;
	logic cur_valid_c;
	logic ram_re_c;
	logic ram_we_c;
	logic [IW-1:0] ram_waddr_c;
	cidst_pkg::entry_t rd_entry;
	cidst_pkg::entry_t wr_entry_c;
	logic [31:0] sat_count_c;
	logic load_c;
	logic [2:0] ld_status_c;
	cidst_pkg::entry_t ld_entry_c;
	logic [6:0] ld_copied_c;
	logic ld_last_c;
	logic rec_done_c;

	assign in_stall   = (state_q != cidst_pkg::ST_IDLE);
	assign in_acc_c   = in_valid && !in_stall;
	assign out_free_c = !out_valid_q || !out_stall;

	cidst_ram #(
		.WIDTH($bits(cidst_pkg::entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we_c),
		.waddr(ram_waddr_c),
		.wdata(wr_entry_c),
		.re   (ram_re_c),
		.raddr(idx_q[IW-1:0]),
		.rdata(rd_entry)
	);

	// compare the slot that came back from the ram with the latched key
	assign hit_c = (state_q == cidst_pkg::ST_REC_SCAN) && chk_s1 && valid_q[idx_s1]
		&& (rd_entry.id == id_q) && (rd_entry.ext == ext_q);
	assign cur_valid_c = valid_q[idx_q[IW-1:0]];

	assign sat_count_c = (rd_entry.count == cidst_pkg::COUNT_TOP) ? rd_entry.count
		: rd_entry.count + 32'd1;
	assign ram_waddr_c = hit_q ? hit_idx_q : free_idx_q;

	always_comb begin
		wr_entry_c.id        = id_q;
		wr_entry_c.ext       = ext_q;
		wr_entry_c.last_time = time_q;
		wr_entry_c.dlc       = dlc_q;
		if (hit_q) begin
			wr_entry_c.count      = sat_count_c;
			wr_entry_c.first_time = rd_entry.first_time;
		end else begin
			wr_entry_c.count      = 32'd1;
			wr_entry_c.first_time = time_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_re_c    = 1'b0;
		ram_we_c    = 1'b0;
		load_c      = 1'b0;
		ld_status_c = cidst_pkg::STAT_END;
		ld_entry_c  = '0;
		ld_copied_c = '0;
		ld_last_c   = 1'b0;
		rec_done_c  = 1'b0;
		unique case (state_q)
			cidst_pkg::ST_IDLE: begin
				if (in_acc_c) begin
					state_d = command ? cidst_pkg::ST_SNAP_RD : cidst_pkg::ST_REC_SCAN;
				end
			end
			cidst_pkg::ST_REC_SCAN: begin
				// stop reading on a hit so the matching slot stays in the read register
				ram_re_c = (idx_q != SLOT_END) && !hit_c;
				if (hit_c || (chk_s1 && idx_s1 == SLOT_LAST)) begin
					state_d = cidst_pkg::ST_REC_FIN;
				end
			end
			cidst_pkg::ST_REC_FIN: begin
				if (out_free_c) begin
					rec_done_c = 1'b1;
					load_c     = 1'b1;
					ld_last_c  = 1'b1;
					if (hit_q) begin
						ram_we_c    = 1'b1;
						ld_status_c = cidst_pkg::STAT_UPDATED;
					end else if (free_found_q) begin
						ram_we_c    = 1'b1;
						ld_status_c = cidst_pkg::STAT_NEW;
					end else begin
						ld_status_c = cidst_pkg::STAT_FULL;
					end
					state_d = cidst_pkg::ST_IDLE;
				end
			end
			cidst_pkg::ST_SNAP_RD: begin
				if (idx_q == SLOT_END || n_q >= max_q) begin
					state_d = cidst_pkg::ST_SNAP_END;
				end else if (cur_valid_c) begin
					ram_re_c = 1'b1;
					state_d  = cidst_pkg::ST_SNAP_OUT;
				end
			end
			cidst_pkg::ST_SNAP_OUT: begin
				if (out_free_c) begin
					load_c      = 1'b1;
					ld_status_c = cidst_pkg::STAT_ENTRY;
					ld_entry_c  = rd_entry;
					state_d     = cidst_pkg::ST_SNAP_RD;
				end
			end
			cidst_pkg::ST_SNAP_END: begin
				if (out_free_c) begin
					load_c      = 1'b1;
					ld_copied_c = n_q;
					ld_last_c   = 1'b1;
					state_d     = cidst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cidst_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cidst_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			valid_q      <= '0;
			idx_q        <= '0;
			chk_s1       <= 1'b0;
			n_q          <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (load_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (ram_we_c && !hit_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end

			chk_s1 <= (state_q == cidst_pkg::ST_REC_SCAN) && ram_re_c;

			if (in_acc_c) begin
				idx_q <= '0;
			end else if (ram_re_c && state_q == cidst_pkg::ST_REC_SCAN) begin
				idx_q <= idx_q + IDX_ONE;
			end else if (state_q == cidst_pkg::ST_SNAP_RD && idx_q != SLOT_END
					&& n_q < max_q && !cur_valid_c) begin
				// unused slot, skip it
				idx_q <= idx_q + IDX_ONE;
			end else if (state_q == cidst_pkg::ST_SNAP_OUT && out_free_c) begin
				idx_q <= idx_q + IDX_ONE;
			end

			if (in_acc_c) begin
				n_q <= '0;
			end else if (state_q == cidst_pkg::ST_SNAP_OUT && out_free_c) begin
				n_q <= n_q + 7'd1;
			end

			if (in_acc_c) begin
				hit_q <= 1'b0;
			end else if (hit_c) begin
				hit_q <= 1'b1;
			end

			if (in_acc_c) begin
				free_found_q <= 1'b0;
			end else if (state_q == cidst_pkg::ST_REC_SCAN && chk_s1
					&& !valid_q[idx_s1]) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc_c) begin
			id_q   <= can_id;
			ext_q  <= extended_format;
			time_q <= rx_time;
			dlc_q  <= data_length_code;
			max_q  <= max_copies;
		end
		if (ram_re_c) begin
			idx_s1 <= idx_q[IW-1:0];
		end
		if (hit_c) begin
			hit_idx_q <= idx_s1;
		end
		// lowest free slot seen so far in this scan
		if (state_q == cidst_pkg::ST_REC_SCAN && chk_s1 && !valid_q[idx_s1]
				&& !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (load_c) begin
			status_q    <= ld_status_c;
			out_entry_q <= ld_entry_c;
			copied_q    <= ld_copied_c;
			last_q      <= ld_last_c;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign entry_id         = out_entry_q.id;
	assign entry_extended   = out_entry_q.ext;
	assign entry_count      = out_entry_q.count;
	assign entry_first_time = out_entry_q.first_time;
	assign entry_last_time  = out_entry_q.last_time;
	assign entry_dlc        = out_entry_q.dlc;
	assign copied_count     = copied_q;
	assign last             = last_q;

	`CIDST_ASSERT(a_rec_result_last, clk, arst_n, (out_valid && (status == cidst_pkg::STAT_NEW || status == cidst_pkg::STAT_UPDATED || status == cidst_pkg::STAT_FULL)) |-> last, "record result without last")
	`CIDST_ASSERT(a_full_only_when_full, clk, arst_n, (rec_done_c && !hit_q && !free_found_q) |-> (&valid_q), "table full reported with a free slot")
	`CIDST_ASSERT(a_copied_bound, clk, arst_n, (out_valid && status == cidst_pkg::STAT_END) |-> (copied_count <= 7'(TABLE_SLOTS)), "snapshot copied more entries than slots")
	`CIDST_ASSERT_NEVER(a_ram_rw_clash, clk, arst_n, ram_we_c && ram_re_c, "slot ram read and write in one cycle")

endmodule

`default_nettype wire
